// ===== src/ilid_pkg.sv =====
// Package for the indexed list block: sizes, codes, request/result types
// and the control/status structs between controller and datapath.
// Depends on nothing; every other file refers to it by scoped names.
package ilid_pkg;

    localparam int CAPACITY = 1024;
    localparam int ELEM_W   = 32;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W  = 11;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [10:0] position;
        logic [31:0] element;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [10:0] length;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch the request
        logic rd_first;  // issue the first memory read of the command
        logic shift;     // move one entry, read the next one
        logic put;       // write the new element at its position
        logic commit;    // update the count and present the result
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        logic is_ins;
        logic ins_ok;
        logic get_ok;
        logic del_ok;
        logic ins_direct;  // insert at the end: nothing to move
        logic del_last;    // delete of the last entry: nothing to move
        logic step_last;   // the entry just read is the last one to move
    } t_dp_sts;

    function automatic logic [ELEM_W-1:0] to_elem(input logic [31:0] v);
        logic [63:0] t;
        t = {32'd0, v};
        return t[ELEM_W-1:0];
    endfunction

    function automatic logic [31:0] from_elem(input logic [ELEM_W-1:0] e);
        logic [63:0] t;
        t = 64'(e);
        return t[31:0];
    endfunction

    function automatic logic [CMP_W-1:0] cnt_cmp(input logic [CNT_W-1:0] c);
        logic [63:0] t;
        t = 64'(c);
        return t[CMP_W-1:0];
    endfunction

    function automatic logic [CMP_W-1:0] pos_cmp(input logic [POS_W-1:0] p);
        logic [63:0] t;
        t = 64'(p);
        return t[CMP_W-1:0];
    endfunction

endpackage

// ===== src/ilid_ctrl.sv =====
// Controller state machine of the indexed list block.
// Depends on ilid_pkg (state-independent structs t_dp_ctl, t_dp_sts).
module ilid_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ilid_pkg::t_dp_sts i_sts,
    output ilid_pkg::t_dp_ctl o_ctl,
    output logic             o_busy,
    output logic             o_done
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SHIFT = 5'b00100,
        S_PUT   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.ins_ok) begin
                    if (i_sts.ins_direct) begin
                        n_state = S_PUT;
                    end else begin
                        o_ctl.rd_first = 1'b1;
                        n_state        = S_SHIFT;
                    end
                end else if (i_sts.get_ok) begin
                    o_ctl.rd_first = 1'b1;
                    n_state        = S_DONE;
                end else if (i_sts.del_ok && !i_sts.del_last) begin
                    o_ctl.rd_first = 1'b1;
                    n_state        = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                o_ctl.shift = 1'b1;
                if (i_sts.step_last) begin
                    n_state = i_sts.is_ins ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                o_ctl.put = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_ctl.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// ===== src/ilid_datapath.sv =====
// Datapath of the indexed list block: request registers, fill count,
// entry memory with registered read, shift pointer and result logic.
// Depends on ilid_pkg.
module ilid_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ilid_pkg::t_req    i_req,
    input  ilid_pkg::t_dp_ctl i_ctl,
    output ilid_pkg::t_dp_sts o_sts,
    output ilid_pkg::t_result o_result
);

    logic [ilid_pkg::ELEM_W-1:0] mem [ilid_pkg::CAPACITY];

    logic [1:0]                  r_cmd;
    logic [ilid_pkg::POS_W-1:0]  r_pos;
    logic [ilid_pkg::ELEM_W-1:0] r_elem;
    logic [ilid_pkg::CNT_W-1:0]  r_count, n_count;
    logic [ilid_pkg::ADDR_W-1:0] r_ptr;
    logic [ilid_pkg::ELEM_W-1:0] r_rdata;

    logic [ilid_pkg::CMP_W-1:0]  cnt_c, pos_c;
    logic [ilid_pkg::ADDR_W-1:0] pos_a, last_a, first_a, next_a, wr_a, rd_a;
    logic [ilid_pkg::ELEM_W-1:0] wr_d;
    logic                        wr_en, rd_en;
    logic                        is_ins, is_get, is_del, full;
    logic [1:0]                  status;

    assign cnt_c  = ilid_pkg::cnt_cmp(r_count);
    assign pos_c  = ilid_pkg::pos_cmp(r_pos);
    assign pos_a  = pos_c[ilid_pkg::ADDR_W-1:0];
    assign last_a = ilid_pkg::ADDR_W'(r_count - 1'b1);

    assign is_ins = (r_cmd == ilid_pkg::CMD_INSERT);
    assign is_get = (r_cmd == ilid_pkg::CMD_GET);
    assign is_del = (r_cmd == ilid_pkg::CMD_DELETE);
    assign full   = (r_count == ilid_pkg::CNT_W'(ilid_pkg::CAPACITY));

    always_comb begin
        o_sts            = '0;
        o_sts.is_ins     = is_ins;
        o_sts.ins_ok     = is_ins && (pos_c <= cnt_c) && !full;
        o_sts.get_ok     = is_get && (pos_c < cnt_c);
        o_sts.del_ok     = is_del && (pos_c < cnt_c);
        o_sts.ins_direct = (pos_c == cnt_c);
        o_sts.del_last   = (pos_c + 1'b1 == cnt_c);
        o_sts.step_last  = is_ins ? (r_ptr == pos_a) : (r_ptr == last_a);
    end

    // first read: insert starts at the top, get reads the slot, delete
    // starts just above the removed slot
    always_comb begin
        case (r_cmd)
            ilid_pkg::CMD_INSERT: first_a = last_a;
            ilid_pkg::CMD_DELETE: first_a = pos_a + 1'b1;
            default:              first_a = pos_a;
        endcase
    end

    assign next_a = is_ins ? (r_ptr - 1'b1) : (r_ptr + 1'b1);

    always_comb begin
        wr_en = 1'b0;
        wr_a  = pos_a;
        wr_d  = r_elem;
        rd_en = 1'b0;
        rd_a  = first_a;
        if (i_ctl.rd_first) begin
            rd_en = 1'b1;
        end
        if (i_ctl.shift) begin
            wr_en = 1'b1;
            wr_a  = is_ins ? (r_ptr + 1'b1) : (r_ptr - 1'b1);
            wr_d  = r_rdata;
            rd_en = !o_sts.step_last;
            rd_a  = next_a;
        end
        if (i_ctl.put) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_a] <= wr_d;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_a];
            r_ptr   <= rd_a;
        end
        if (i_ctl.load) begin
            r_cmd  <= i_req.command;
            r_pos  <= i_req.position;
            r_elem <= ilid_pkg::to_elem(i_req.element);
        end
    end

    always_comb begin
        if (o_sts.ins_ok) begin
            status = ilid_pkg::ST_DONE;
        end else if (is_ins && (pos_c <= cnt_c)) begin
            status = ilid_pkg::ST_FULL;
        end else if (o_sts.get_ok || o_sts.del_ok) begin
            status = ilid_pkg::ST_DONE;
        end else begin
            status = ilid_pkg::ST_RANGE;
        end
    end

    always_comb begin
        n_count = r_count;
        if (o_sts.ins_ok) begin
            n_count = r_count + 1'b1;
        end else if (o_sts.del_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.commit) begin
            r_count <= n_count;
        end
    end

    always_comb begin
        logic [63:0] len;
        len                 = 64'(n_count);
        o_result.status     = status;
        o_result.read_value = o_sts.get_ok ? ilid_pkg::from_elem(r_rdata) : 32'd0;
        o_result.length     = len[10:0];
    end

endmodule

// ===== src/indexed_list_insert_delete.sv =====
// Indexed list with insert, get and delete at a position.
// Insert and delete shift the entries behind the position, one entry per cycle; get,
// failed commands, insert at the end and delete of the last entry move nothing.
// One request at a time: the next is accepted in the cycle after the strobe.
// Sync active-low reset empties the list.
module indexed_list_insert_delete (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ilid_pkg::t_req    i_req,
    output logic              o_busy,
    output logic              o_done,
    output ilid_pkg::t_result o_result
);

    ilid_pkg::t_dp_ctl ctl;
    ilid_pkg::t_dp_sts sts;

    // sequence the request: check, shift entries, write, report
    ilid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    // hold the request, the count and the entries; build the result
    ilid_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_result (o_result)
    );

    // a result is only presented while a request is in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy)
        else $error("result strobe outside a request");

    // an accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_done))
        else $error("accepted request did not start");

    // the strobe lasts one cycle and the block frees up right after
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !o_busy))
        else $error("result strobe not a single pulse");

    // reported length never exceeds capacity
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.length <= 11'(ilid_pkg::CAPACITY)))
        else $error("length above capacity");

endmodule
